[design/fpma_pkg.sv]
// Shared types and constants for the fence peak moving average block.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none

package fpma_pkg;

    // Configuration registers are 16 bits wide. The millivolt result is 16 bits.
    localparam int unsigned CFG_W = 16;
    localparam int unsigned MV_W  = 16;
    localparam int unsigned APB_W = 32;
    localparam int unsigned ADDR_W = 3;

    localparam logic [CFG_W-1:0] WINDOW_LENGTH_RESET = 16'd20000;
    localparam logic [CFG_W-1:0] FULL_SCALE_RESET    = 16'd12000;

    typedef enum logic {
        REG_WINDOW_LENGTH = 1'b0,
        REG_FULL_SCALE    = 1'b1
    } t_reg_idx;

    // Load enables of the five result pipeline stages.
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
        logic ld5;
    } t_stage_en;

endpackage

`default_nettype wire

[design/fence_peak_moving_average.sv]
// Fence peak moving average: per-channel window peaks, boxcar average of
// the last AVG_DEPTH peaks, and millivolt scaling. Uses fpma_pkg, fpma_regs,
// fpma_window and fpma_scale.
// Takes one sample pair per cycle while o_stall is low; a pair that closes
// a window yields a result from the five-stage result pipeline, others none.
// Reset clears the sample count, peaks, rings and totals and loads the
// registers with a window of 20000 samples and a full scale of 12000 mV.
`default_nettype none

module fence_peak_moving_average #(
    parameter int unsigned ADC_BITS  = 10,
    parameter int unsigned AVG_DEPTH = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [fpma_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [fpma_pkg::APB_W-1:0]   pwdata,
    output logic      [fpma_pkg::APB_W-1:0]   prdata,
    output logic                              pready,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [ADC_BITS-1:0]          i_pos_sample,
    input  wire logic [ADC_BITS-1:0]          i_neg_sample,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic      [ADC_BITS-1:0]          o_pos_average,
    output logic      [ADC_BITS-1:0]          o_neg_average,
    output logic      [fpma_pkg::MV_W-1:0]    o_pos_millivolts,
    output logic      [fpma_pkg::MV_W-1:0]    o_neg_millivolts
);

    localparam int unsigned SUM_W = $clog2(AVG_DEPTH * ((1 << ADC_BITS) - 1) + 1);

    logic [fpma_pkg::CFG_W-1:0] window_length;
    logic [fpma_pkg::CFG_W-1:0] full_scale_mv;
    logic                       accept;
    logic                       close;
    logic [SUM_W-1:0]           pos_sum;
    logic [SUM_W-1:0]           neg_sum;
    fpma_pkg::t_stage_en        en;
    logic                       r_v1, r_v2, r_v3, r_v4, r_v5;

    fpma_regs u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_window_length (window_length),
        .o_full_scale_mv (full_scale_mv)
    );

    // Each stage loads when it is empty or its content moves on.
    always_comb begin
        en.ld5 = !r_v5 || !i_stall;
        en.ld4 = !r_v4 || en.ld5;
        en.ld3 = !r_v3 || en.ld4;
        en.ld2 = !r_v2 || en.ld3;
        en.ld1 = !r_v1 || en.ld2;
    end

    assign o_stall = !en.ld1;
    assign accept  = i_valid && en.ld1;

    fpma_window #(
        .ADC_BITS  (ADC_BITS),
        .AVG_DEPTH (AVG_DEPTH)
    ) u_window (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_pos_sample    (i_pos_sample),
        .i_neg_sample    (i_neg_sample),
        .i_window_length (window_length),
        .o_close         (close),
        .o_pos_sum       (pos_sum),
        .o_neg_sum       (neg_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en.ld1) begin
                r_v1 <= accept && close;
            end
            if (en.ld2) begin
                r_v2 <= r_v1;
            end
            if (en.ld3) begin
                r_v3 <= r_v2;
            end
            if (en.ld4) begin
                r_v4 <= r_v3;
            end
            if (en.ld5) begin
                r_v5 <= r_v4;
            end
        end
    end

    fpma_scale #(
        .ADC_BITS  (ADC_BITS),
        .AVG_DEPTH (AVG_DEPTH)
    ) u_pos_scale (
        .i_clk           (i_clk),
        .i_en            (en),
        .i_sum           (pos_sum),
        .i_full_scale_mv (full_scale_mv),
        .o_average       (o_pos_average),
        .o_millivolts    (o_pos_millivolts)
    );

    fpma_scale #(
        .ADC_BITS  (ADC_BITS),
        .AVG_DEPTH (AVG_DEPTH)
    ) u_neg_scale (
        .i_clk           (i_clk),
        .i_en            (en),
        .i_sum           (neg_sum),
        .i_full_scale_mv (full_scale_mv),
        .o_average       (o_neg_average),
        .o_millivolts    (o_neg_millivolts)
    );

    assign o_valid = r_v5;

endmodule

`default_nettype wire

[design/fpma_regs.sv]
// Configuration register file with an APB-style write and read port.
// Depends on fpma_pkg for register widths, reset values and indexes.
`default_nettype none

module fpma_regs (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [fpma_pkg::ADDR_W-1:0] paddr,
    input  wire logic [fpma_pkg::APB_W-1:0]  pwdata,
    output logic      [fpma_pkg::APB_W-1:0]  prdata,
    output logic                             pready,
    output logic      [fpma_pkg::CFG_W-1:0]  o_window_length,
    output logic      [fpma_pkg::CFG_W-1:0]  o_full_scale_mv
);

    logic [fpma_pkg::CFG_W-1:0] r_window_length;
    logic [fpma_pkg::CFG_W-1:0] r_full_scale_mv;
    logic                       wr_en;
    fpma_pkg::t_reg_idx         reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = fpma_pkg::t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= fpma_pkg::WINDOW_LENGTH_RESET;
            r_full_scale_mv <= fpma_pkg::FULL_SCALE_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                fpma_pkg::REG_WINDOW_LENGTH: begin
                    r_window_length <= pwdata[fpma_pkg::CFG_W-1:0];
                end
                fpma_pkg::REG_FULL_SCALE: begin
                    r_full_scale_mv <= pwdata[fpma_pkg::CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            fpma_pkg::REG_WINDOW_LENGTH: begin
                prdata = fpma_pkg::APB_W'(r_window_length);
            end
            fpma_pkg::REG_FULL_SCALE: begin
                prdata = fpma_pkg::APB_W'(r_full_scale_mv);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign o_window_length = r_window_length;
    assign o_full_scale_mv = r_full_scale_mv;

endmodule

`default_nettype wire

[design/fpma_window.sv]
// Window peak tracking, rings of recent peaks and their running totals.
// Depends on fpma_pkg for the configuration width.
`default_nettype none

module fpma_window #(
    parameter int unsigned ADC_BITS  = 10,
    parameter int unsigned AVG_DEPTH = 8,
    localparam int unsigned SUM_W    = $clog2(AVG_DEPTH * ((1 << ADC_BITS) - 1) + 1)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire logic [ADC_BITS-1:0]        i_pos_sample,
    input  wire logic [ADC_BITS-1:0]        i_neg_sample,
    input  wire logic [fpma_pkg::CFG_W-1:0] i_window_length,
    output logic                            o_close,
    output logic [SUM_W-1:0]                o_pos_sum,
    output logic [SUM_W-1:0]                o_neg_sum
);

    localparam int unsigned CNT_W = fpma_pkg::CFG_W;

    logic [CNT_W-1:0]    r_count;
    logic [ADC_BITS-1:0] r_pos_peak;
    logic [ADC_BITS-1:0] r_neg_peak;
    logic [SUM_W-1:0]    r_pos_sum;
    logic [SUM_W-1:0]    r_neg_sum;
    // Rings kept as shift lines: tap 0 is the newest peak, the last tap the oldest.
    logic [ADC_BITS-1:0] r_pos_ring [AVG_DEPTH];
    logic [ADC_BITS-1:0] r_neg_ring [AVG_DEPTH];

    logic [ADC_BITS-1:0] pos_peak;
    logic [ADC_BITS-1:0] neg_peak;
    logic [CNT_W:0]      taken;
    logic [SUM_W-1:0]    n_pos_sum;
    logic [SUM_W-1:0]    n_neg_sum;

    assign pos_peak = (i_pos_sample > r_pos_peak) ? i_pos_sample : r_pos_peak;
    assign neg_peak = (i_neg_sample > r_neg_peak) ? i_neg_sample : r_neg_peak;
    assign taken    = {1'b0, r_count} + 1'b1;

    // A length of zero closes on every sample, just like a length of one.
    assign o_close  = taken >= {1'b0, i_window_length};

    assign n_pos_sum = r_pos_sum - SUM_W'(r_pos_ring[AVG_DEPTH-1]) + SUM_W'(pos_peak);
    assign n_neg_sum = r_neg_sum - SUM_W'(r_neg_ring[AVG_DEPTH-1]) + SUM_W'(neg_peak);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_pos_peak <= '0;
            r_neg_peak <= '0;
            r_pos_sum  <= '0;
            r_neg_sum  <= '0;
            for (int i = 0; i < AVG_DEPTH; i++) begin
                r_pos_ring[i] <= '0;
                r_neg_ring[i] <= '0;
            end
        end else if (i_accept) begin
            if (o_close) begin
                r_count    <= '0;
                r_pos_peak <= '0;
                r_neg_peak <= '0;
                r_pos_sum  <= n_pos_sum;
                r_neg_sum  <= n_neg_sum;
                r_pos_ring[0] <= pos_peak;
                r_neg_ring[0] <= neg_peak;
                for (int i = 1; i < AVG_DEPTH; i++) begin
                    r_pos_ring[i] <= r_pos_ring[i-1];
                    r_neg_ring[i] <= r_neg_ring[i-1];
                end
            end else begin
                r_count    <= taken[CNT_W-1:0];
                r_pos_peak <= pos_peak;
                r_neg_peak <= neg_peak;
            end
        end
    end

    assign o_pos_sum = n_pos_sum;
    assign o_neg_sum = n_neg_sum;

endmodule

`default_nettype wire

[design/fpma_scale.sv]
// Result datapath of one channel: ring average and millivolt scaling.
// Depends on fpma_pkg for the stage enable struct and field widths.
`default_nettype none

module fpma_scale #(
    parameter int unsigned ADC_BITS  = 10,
    parameter int unsigned AVG_DEPTH = 8,
    localparam int unsigned SUM_W    = $clog2(AVG_DEPTH * ((1 << ADC_BITS) - 1) + 1)
) (
    input  wire logic                       i_clk,
    input  wire fpma_pkg::t_stage_en        i_en,
    input  wire logic [SUM_W-1:0]           i_sum,
    input  wire logic [fpma_pkg::CFG_W-1:0] i_full_scale_mv,
    output logic [ADC_BITS-1:0]             o_average,
    output logic [fpma_pkg::MV_W-1:0]       o_millivolts
);

    // Exact division by the ring depth through a reciprocal multiply.
    localparam int unsigned AVG_L     = $clog2(AVG_DEPTH);
    localparam int unsigned AVG_SHIFT = SUM_W + AVG_L;
    localparam logic [63:0] AVG_M     = ((64'd1 << AVG_SHIFT) + 64'(AVG_DEPTH) - 64'd1)
                                        / 64'(AVG_DEPTH);
    localparam int unsigned AVGP_W    = 2 * SUM_W + 1;
    // Division by the full ADC code uses the series 1/(2^B - 1) = sum of 2^-kB.
    localparam int unsigned PROD_W    = ADC_BITS + fpma_pkg::CFG_W;
    localparam int unsigned APPROX_W  = PROD_W + 1;
    localparam int unsigned DIV_TERMS = (PROD_W - 1) / ADC_BITS + 1;
    localparam int unsigned Q_W       = APPROX_W - ADC_BITS;
    localparam int unsigned REM_W     = PROD_W + 2;
    localparam logic [REM_W-1:0] DIV_D = REM_W'((64'd1 << ADC_BITS) - 64'd1);

    logic [SUM_W-1:0]    r_sum1;
    logic [ADC_BITS-1:0] r_avg2;
    logic [ADC_BITS-1:0] r_avg3;
    logic [PROD_W-1:0]   r_prod3;
    logic [ADC_BITS-1:0] r_avg4;
    logic [PROD_W-1:0]   r_prod4;
    logic [APPROX_W-1:0] r_approx4;
    logic [ADC_BITS-1:0] r_avg5;
    logic [fpma_pkg::MV_W-1:0] r_mv5;

    logic [AVGP_W-1:0]   avg_prod;
    logic [APPROX_W-1:0] n_approx;
    logic [Q_W-1:0]      quot;
    logic [REM_W-1:0]    rem;
    logic [Q_W-1:0]      n_mv;

    assign avg_prod = AVGP_W'(r_sum1) * AVGP_W'(AVG_M[SUM_W:0]);

    always_comb begin
        n_approx = '0;
        for (int k = 0; k < DIV_TERMS; k++) begin
            n_approx = n_approx + APPROX_W'(r_prod3 >> (k * ADC_BITS));
        end
    end

    // The series estimate is at most one short; one compare fixes it.
    assign quot = r_approx4[APPROX_W-1:ADC_BITS];
    assign rem  = REM_W'(r_prod4) + REM_W'(quot) - (REM_W'(quot) << ADC_BITS);
    assign n_mv = quot + Q_W'(rem >= DIV_D);

    always_ff @(posedge i_clk) begin
        if (i_en.ld1) begin
            r_sum1 <= i_sum;
        end
        if (i_en.ld2) begin
            r_avg2 <= avg_prod[AVG_SHIFT +: ADC_BITS];
        end
        if (i_en.ld3) begin
            r_avg3  <= r_avg2;
            r_prod3 <= PROD_W'(r_avg2) * PROD_W'(i_full_scale_mv);
        end
        if (i_en.ld4) begin
            r_avg4    <= r_avg3;
            r_prod4   <= r_prod3;
            r_approx4 <= n_approx;
        end
        if (i_en.ld5) begin
            r_avg5 <= r_avg4;
            r_mv5  <= n_mv[fpma_pkg::MV_W-1:0];
        end
    end

    assign o_average    = r_avg5;
    assign o_millivolts = r_mv5;

endmodule

`default_nettype wire
